// ----- rtl/get_pkg.sv -----
// Shared types and constants for the generational entity table.
// Used by the controller, the datapath and the top level.
package get_pkg;
	localparam int MaxSlots = 1024;
	localparam int MaskBits = 32;
	localparam int IdxW = $clog2(MaxSlots);
	localparam int CntW = IdxW + 1;

	localparam logic [2:0] FN_CREATE = 3'd0;
	localparam logic [2:0] FN_DESTROY = 3'd1;
	localparam logic [2:0] FN_ADD = 3'd2;
	localparam logic [2:0] FN_REMOVE = 3'd3;
	localparam logic [2:0] FN_TEST = 3'd4;
	localparam logic [2:0] FN_FIND = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	typedef struct packed {
		logic load;      // capture the item
		logic rd_slot;   // read slot at the current index
		logic rd_free;   // read top of the free stack
		logic exec;      // evaluate and write back
		logic scan_step; // evaluate one slot of a scan
		logic scan_adv;  // advance scan index
	} ctl_cmd_t;

	typedef struct packed {
		logic is_find;
		logic scan_done;
	} ctl_sts_t;
endpackage

// ----- rtl/get_ctrl.sv -----
// Controller state machine for the generational entity table.
// Depends on get_pkg.
module get_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output get_pkg::ctl_cmd_t cmd,
	input  get_pkg::ctl_sts_t sts
);
	import get_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_SWAIT = 3'd4;

	logic [2:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_READ;
				S_READ: state_q <= sts.is_find ? S_SWAIT : S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				S_SWAIT: state_q <= S_SCAN;
				S_SCAN: state_q <= sts.scan_done ? S_IDLE : S_SCAN;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				cmd.rd_free = start;
			end
			S_READ: begin
				cmd.rd_slot = 1'b1;
			end
			S_EXEC: cmd.exec = 1'b1;
			S_SWAIT: begin
				cmd.rd_slot = 1'b1;
				cmd.scan_adv = 1'b1;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.rd_slot = 1'b1;
				cmd.scan_adv = 1'b1;
			end
			default: cmd = '0;
		endcase
	end
endmodule

// ----- rtl/get_dp.sv -----
// Datapath for the generational entity table: slot memories, free stack,
// counters and result registers. Depends on get_pkg.
module get_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  get_pkg::ctl_cmd_t          cmd,
	output get_pkg::ctl_sts_t          sts,
	input  logic [2:0]                 func,
	input  logic [get_pkg::IdxW-1:0]   entity_index,
	input  logic [31:0]                entity_version,
	input  logic [4:0]                 component_id,
	input  logic [31:0]                query_mask,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [get_pkg::IdxW-1:0]   out_index,
	output logic [31:0]                out_version,
	output logic                       has_component
);
	import get_pkg::*;

	logic [31:0] ver_mem [MaxSlots];
	logic [MaskBits-1:0] mask_mem [MaxSlots];
	logic [IdxW-1:0] free_mem [MaxSlots];
	logic live_mem [MaxSlots];
	logic [CntW-1:0] free_cnt_q, used_cnt_q;

	logic [2:0] func_q;
	logic [IdxW-1:0] idx_q, scan_q, rd_idx_s1;
	logic [31:0] ver_q, qmask_q;
	logic [4:0] cid_q;
	logic [31:0] rd_ver_s1;
	logic [MaskBits-1:0] rd_mask_s1;
	logic [IdxW-1:0] rd_free_s1;
	logic rd_live_s1, rd_inr_s1, rd_valid_s1;

	logic [IdxW-1:0] rd_addr;
	logic [MaskBits-1:0] cbit, qm;
	logic cur_ok, match, use_free, full;
	logic [IdxW-1:0] new_idx;

	assign rd_addr = cmd.scan_adv ? scan_q :
		((func_q == FN_CREATE && use_free) ? rd_free_s1 : idx_q);
	assign cbit = (int'(cid_q) < MaskBits) ? (MaskBits'(1) << cid_q) : '0;
	assign qm = MaskBits'(qmask_q);
	assign use_free = (free_cnt_q != '0);
	assign full = (used_cnt_q == CntW'(MaxSlots));
	assign new_idx = use_free ? rd_free_s1 : used_cnt_q[IdxW-1:0];
	assign cur_ok = rd_inr_s1 && rd_live_s1 && (rd_ver_s1 == ver_q);
	assign match = rd_valid_s1 && rd_live_s1 && ((rd_mask_s1 & qm) == qm)
		&& (qmask_q >> MaskBits) == '0;

	assign sts.is_find = (func_q == FN_FIND);
	assign sts.scan_done = match || !rd_valid_s1 || (rd_idx_s1 == IdxW'(MaxSlots - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			idx_q <= entity_index;
			ver_q <= entity_version;
			cid_q <= component_id;
			qmask_q <= query_mask;
		end
		if (cmd.rd_slot) begin
			rd_ver_s1 <= ver_mem[rd_addr];
			rd_mask_s1 <= mask_mem[rd_addr];
			rd_live_s1 <= live_mem[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
		if (cmd.rd_free) rd_free_s1 <= free_mem[free_cnt_q[IdxW-1:0] - IdxW'(1)];
		if (cmd.exec) begin
			case (func_q)
				FN_CREATE: if (use_free || !full) begin
					live_mem[new_idx] <= 1'b1;
					if (!use_free) begin
						ver_mem[new_idx] <= '0;
						mask_mem[new_idx] <= '0;
					end
				end
				FN_DESTROY: if (cur_ok) begin
					ver_mem[idx_q] <= rd_ver_s1 + 32'd1;
					mask_mem[idx_q] <= '0;
					live_mem[idx_q] <= 1'b0;
					free_mem[free_cnt_q[IdxW-1:0]] <= idx_q;
				end
				FN_ADD: if (rd_inr_s1 && rd_live_s1) mask_mem[idx_q] <= rd_mask_s1 | cbit;
				FN_REMOVE: if (cur_ok) mask_mem[idx_q] <= rd_mask_s1 & ~cbit;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= '0;
			used_cnt_q <= '0;
			rd_inr_s1 <= 1'b0;
			rd_valid_s1 <= 1'b0;
			scan_q <= '0;
			done <= 1'b0;
			status <= ST_OK;
			out_index <= '0;
			out_version <= '0;
			has_component <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cmd.load) scan_q <= entity_index;
			if (cmd.rd_slot) begin
				rd_inr_s1 <= {1'b0, rd_addr} < used_cnt_q;
				rd_valid_s1 <= {1'b0, rd_addr} < used_cnt_q;
			end
			if (cmd.scan_adv && scan_q != IdxW'(MaxSlots - 1)) scan_q <= scan_q + IdxW'(1);
			if (cmd.scan_step && sts.scan_done) begin
				done <= 1'b1;
				has_component <= 1'b0;
				if (match) begin
					status <= ST_OK;
					out_index <= rd_idx_s1;
					out_version <= rd_ver_s1;
				end else begin
					status <= ST_NOMATCH;
					out_index <= '0;
					out_version <= '0;
				end
			end
			if (cmd.exec) begin
				done <= 1'b1;
				status <= ST_OK;
				out_index <= '0;
				out_version <= '0;
				has_component <= 1'b0;
				case (func_q)
					FN_CREATE: begin
						if (use_free) begin
							free_cnt_q <= free_cnt_q - CntW'(1);
							out_index <= rd_free_s1;
							out_version <= rd_ver_s1;
						end else if (!full) begin
							used_cnt_q <= used_cnt_q + CntW'(1);
							out_index <= used_cnt_q[IdxW-1:0];
						end else begin
							status <= ST_FULL;
						end
					end
					FN_DESTROY: begin
						if (cur_ok) begin
							free_cnt_q <= free_cnt_q + CntW'(1);
						end else begin
							status <= ST_STALE;
						end
					end
					FN_ADD: if (!(rd_inr_s1 && rd_live_s1)) status <= ST_STALE;
					FN_REMOVE: if (!cur_ok) status <= ST_STALE;
					FN_TEST: begin
						if (rd_inr_s1) has_component <= |(rd_mask_s1 & cbit);
						else status <= ST_STALE;
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- rtl/generational_entity_table.sv -----
// Generational entity table: a slot map with versions, component masks and a free stack.
// Table operations load the item and read the free-stack top, read the slot, then execute
// and raise the strobe; find next reads the slots upward from entity_index one at a time,
// set by the single read port of the slot memories. A new item is accepted in the strobe cycle.
// Reset clears both counters; slot contents are defined once created; the receiver cannot stall.
// Depends on get_pkg, get_ctrl and get_dp.
module generational_entity_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               func,
	input  logic [get_pkg::IdxW-1:0] entity_index,
	input  logic [31:0]              entity_version,
	input  logic [4:0]               component_id,
	input  logic [31:0]              query_mask,
	output logic                     done,
	output logic [1:0]               status,
	output logic [get_pkg::IdxW-1:0] out_index,
	output logic [31:0]              out_version,
	output logic                     has_component
);
	import get_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	get_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
	);

	get_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(func), .entity_index(entity_index), .entity_version(entity_version),
		.component_id(component_id), .query_mask(query_mask),
		.done(done), .status(status), .out_index(out_index),
		.out_version(out_version), .has_component(has_component)
	);
endmodule
